### sv/fragment_reassembler_top_defines.svh
// ----------------------------------------------------------------------------
// Fragment reassembler assertion macros
// Property check wrappers shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLER_TOP_DEFINES_SVH
`define FRAGMENT_REASSEMBLER_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication property, checked out of reset
`define FRAGR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fragment reassembler assertion failed");
// next-cycle implication property, checked out of reset
`define FRAGR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fragment reassembler assertion failed");
`else
`define FRAGR_ASSERT(label, clk, rstn, prop)
`define FRAGR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### sv/fragr_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembler package
// Item kinds, controller states, command/status bundles and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fragr_pkg;

    localparam int unsigned HDR_BYTES = 4;
    localparam logic [7:0]  FRAG_TYPE = 8'h01;
    localparam int unsigned LEN_W     = 11;
    localparam logic [10:0] LEN_MAX   = 11'h7FF;
    localparam int unsigned SUM_W     = 16;   // 255 fragments * 255 bytes
    localparam int unsigned RADDR_W   = 10;
    localparam int unsigned EXT_W     = 13;   // holds any store size up to 4096

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FIN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic do_header;
        logic do_byte;
        logic do_read;
        logic do_finish;
        logic clear_step;
        logic load_out;
    } fragr_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  hdr_clear;
        logic  byte_ok;
        logic  last_byte;
        logic  clr_last;
        logic  out_free;
    } fragr_status_t;

endpackage

`default_nettype wire

### sv/fragr_ram.sv
// ----------------------------------------------------------------------------
// Fragment reassembler generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fragr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/fragr_dpath.sv
// ----------------------------------------------------------------------------
// Fragment reassembler datapath
// Header checks, write window, length table, running sum, store, result regs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fragment_reassembler_top_defines.svh"

module fragr_dpath import fragr_pkg::*; #(
    parameter int STORE_BYTES = 1024,
    parameter int FRAG_STRIDE = 57,
    parameter int MAX_FRAGS   = 255
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fragr_cmd_t          cmd,
    output fragr_status_t            status,
    input  wire logic [1:0]          s_kind,
    input  wire logic [7:0]          s_msg_type,
    input  wire logic [7:0]          s_frag_index,
    input  wire logic [7:0]          s_frag_total,
    input  wire logic [7:0]          s_message_id,
    input  wire logic [7:0]          s_packet_len,
    input  wire logic [7:0]          s_data_byte,
    input  wire logic [RADDR_W-1:0]  s_read_addr,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_header_ok,
    output logic                     m_done_res,
    output logic [LEN_W-1:0]         m_total_length,
    output logic [7:0]               m_read_data
);

    localparam int SAW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PW  = $clog2(STORE_BYTES + 1);
    localparam int FW  = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;

    // captured transaction
    kind_t              kind_reg;
    logic [7:0]         type_reg, idx_reg, tot_reg, id_reg, plen_reg, data_reg;
    logic [RADDR_W-1:0] raddr_reg;

    // bookkeeping
    logic [MAX_FRAGS-1:0] fv_reg, fv_next;
    logic [7:0]       seen_reg, seen_next;
    logic [7:0]       etot_reg, etot_next;
    logic [7:0]       eid_reg, eid_next;
    logic             done_reg, done_next;
    logic [LEN_W-1:0] mlen_reg, mlen_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [PW-1:0]    wp_reg, wp_next;
    logic [7:0]       bl_reg, bl_next;
    logic [7:0]       pi_reg, pi_next;
    logic [7:0]       flen_reg, flen_next;
    logic [SAW-1:0]   clr_addr_reg, clr_addr_next;
    logic             ok_reg, ok_next;
    logic             rdok_reg, rdok_next;
    logic             mv_reg, mv_next;
    logic             mok_reg, mdone_reg;
    logic [LEN_W-1:0] mlen_out_reg;
    logic [7:0]       mrd_reg;

    // header decode
    logic             pre_ok, hdr_clear, hdr_ok, fits;
    logic [7:0]       eff_id, hdr_flen;
    logic [15:0]      off;
    // payload and read
    logic             byte_ok, last_byte, clr_last;
    logic [EXT_W-1:0] rd_ext;
    logic             rd_in;
    // finish
    logic [FW-1:0]    pi_idx;
    logic [7:0]       old_len;
    logic             first_seen;
    logic [SUM_W-1:0] sum_fin;
    logic [7:0]       seen_fin;

    // memories
    logic           st_we;
    logic [SAW-1:0] st_waddr;
    logic [7:0]     st_wdata, st_rdata;
    logic [7:0]     lt_rdata;

    assign pre_ok = (type_reg == FRAG_TYPE) && (plen_reg >= 8'(HDR_BYTES + 1))
                 && (tot_reg != 8'd0) && (tot_reg <= 8'(MAX_FRAGS))
                 && (idx_reg < tot_reg);
    assign hdr_clear = pre_ok && (idx_reg == 8'd0);
    assign eff_id    = hdr_clear ? id_reg : eid_reg;
    assign hdr_flen  = plen_reg - 8'(HDR_BYTES);
    assign off       = 16'(idx_reg) * 16'(FRAG_STRIDE);
    assign fits      = (17'(off) + 17'(hdr_flen)) <= 17'(STORE_BYTES);
    assign hdr_ok    = pre_ok && (id_reg == eff_id) && fits;

    assign byte_ok   = (bl_reg != 8'd0) && (wp_reg < PW'(STORE_BYTES));
    assign last_byte = (bl_reg == 8'd1);
    assign clr_last  = (clr_addr_reg == SAW'(STORE_BYTES - 1));

    assign rd_ext = EXT_W'(raddr_reg);
    assign rd_in  = rd_ext < EXT_W'(STORE_BYTES);

    assign pi_idx     = pi_reg[FW-1:0];
    assign first_seen = !fv_reg[pi_idx];
    assign old_len    = first_seen ? 8'd0 : lt_rdata;
    assign seen_fin   = seen_reg + 8'(first_seen);
    assign sum_fin    = (pi_reg < etot_reg)
                      ? (sum_reg - SUM_W'(old_len) + SUM_W'(flen_reg)) : sum_reg;

    always_comb begin
        fv_next       = fv_reg;
        seen_next     = seen_reg;
        etot_next     = etot_reg;
        eid_next      = eid_reg;
        done_next     = done_reg;
        mlen_next     = mlen_reg;
        sum_next      = sum_reg;
        wp_next       = wp_reg;
        bl_next       = bl_reg;
        pi_next       = pi_reg;
        flen_next     = flen_reg;
        clr_addr_next = clr_addr_reg;
        ok_next       = ok_reg;
        rdok_next     = rdok_reg;
        mv_next       = mv_reg;

        if (cmd.capture) begin
            ok_next   = 1'b0;
            rdok_next = 1'b0;
        end
        if (cmd.do_header) begin
            if (hdr_clear) begin
                fv_next   = '0;
                seen_next = 8'd0;
                etot_next = tot_reg;
                eid_next  = id_reg;
                done_next = 1'b0;
                mlen_next = '0;
                sum_next  = '0;
            end
            ok_next = hdr_ok;
            bl_next = hdr_ok ? hdr_flen : 8'd0;
            if (hdr_ok) begin
                wp_next   = off[PW-1:0];
                pi_next   = idx_reg;
                flen_next = hdr_flen;
            end
        end
        if (cmd.do_byte) begin
            ok_next = byte_ok;
            if (byte_ok) begin
                wp_next = wp_reg + PW'(1);
                bl_next = bl_reg - 8'd1;
            end
        end
        if (cmd.do_read) begin
            rdok_next = rd_in;
        end
        if (cmd.do_finish) begin
            fv_next[pi_idx] = 1'b1;
            seen_next       = seen_fin;
            sum_next        = sum_fin;
            if (seen_fin == etot_reg) begin
                done_next = 1'b1;
                mlen_next = (sum_fin > SUM_W'(LEN_MAX)) ? LEN_MAX : sum_fin[LEN_W-1:0];
            end
        end
        if (cmd.clear_step) begin
            clr_addr_next = clr_last ? '0 : clr_addr_reg + SAW'(1);
        end
        if (cmd.load_out) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg       <= '0;
            seen_reg     <= '0;
            etot_reg     <= '0;
            eid_reg      <= '0;
            done_reg     <= 1'b0;
            mlen_reg     <= '0;
            sum_reg      <= '0;
            wp_reg       <= '0;
            bl_reg       <= '0;
            pi_reg       <= '0;
            clr_addr_reg <= '0;
            mv_reg       <= 1'b0;
        end else begin
            fv_reg       <= fv_next;
            seen_reg     <= seen_next;
            etot_reg     <= etot_next;
            eid_reg      <= eid_next;
            done_reg     <= done_next;
            mlen_reg     <= mlen_next;
            sum_reg      <= sum_next;
            wp_reg       <= wp_next;
            bl_reg       <= bl_next;
            pi_reg       <= pi_next;
            clr_addr_reg <= clr_addr_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        flen_reg <= flen_next;
        ok_reg   <= ok_next;
        rdok_reg <= rdok_next;
        if (cmd.capture) begin
            kind_reg  <= kind_t'(s_kind);
            type_reg  <= s_msg_type;
            idx_reg   <= s_frag_index;
            tot_reg   <= s_frag_total;
            id_reg    <= s_message_id;
            plen_reg  <= s_packet_len;
            data_reg  <= s_data_byte;
            raddr_reg <= s_read_addr;
        end
        if (cmd.load_out) begin
            mok_reg      <= ok_reg;
            mdone_reg    <= done_reg;
            mlen_out_reg <= done_reg ? mlen_reg : '0;
            mrd_reg      <= rdok_reg ? st_rdata : 8'd0;
        end
    end

    // store: clearing sweep and payload writes share the write port
    assign st_we    = cmd.clear_step || (cmd.do_byte && byte_ok);
    assign st_waddr = cmd.clear_step ? clr_addr_reg : wp_reg[SAW-1:0];
    assign st_wdata = cmd.clear_step ? 8'd0 : data_reg;

    fragr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (cmd.do_read),
        .raddr (rd_ext[SAW-1:0]),
        .rdata (st_rdata)
    );

    // length table; entries without a valid bit read as zero
    fragr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAGS)
    ) u_lengths (
        .aclk  (aclk),
        .we    (cmd.do_finish),
        .waddr (pi_idx),
        .wdata (flen_reg),
        .re    (cmd.do_byte),
        .raddr (pi_idx),
        .rdata (lt_rdata)
    );

    always_comb begin
        status.kind      = kind_reg;
        status.hdr_clear = hdr_clear;
        status.byte_ok   = byte_ok;
        status.last_byte = last_byte;
        status.clr_last  = clr_last;
        status.out_free  = !mv_reg || m_ready;
    end

    assign m_valid        = mv_reg;
    assign m_header_ok    = mok_reg;
    assign m_done_res     = mdone_reg;
    assign m_total_length = mlen_out_reg;
    assign m_read_data    = mrd_reg;

    `FRAGR_ASSERT(a_window_fits, aclk, aresetn, (bl_reg != 8'd0) |-> ((17'(wp_reg) + 17'(bl_reg)) <= 17'(STORE_BYTES)))
    `FRAGR_ASSERT(a_len_zero_until_done, aclk, aresetn, !done_reg |-> (mlen_reg == '0))
    `FRAGR_ASSERT(a_sweep_only_when_clearing, aclk, aresetn, (clr_addr_reg != '0) |-> cmd.clear_step)

endmodule

`default_nettype wire

### sv/fragr_ctrl.sv
// ----------------------------------------------------------------------------
// Fragment reassembler controller
// Sequences accept, execute, finish, clearing sweep and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fragment_reassembler_top_defines.svh"

module fragr_ctrl import fragr_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire fragr_status_t status,
    output fragr_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   clr_resp_reg, clr_resp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_resp_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_resp_reg <= clr_resp_next;
        end
    end

    // next state
    always_comb begin
        state_next    = state_reg;
        clr_resp_next = clr_resp_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next    = clr_resp_reg ? ST_RESP : ST_IDLE;
                    clr_resp_next = 1'b0;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (status.kind)
                    KIND_HEADER: begin
                        if (status.hdr_clear) begin
                            state_next    = ST_CLEAR;
                            clr_resp_next = 1'b1;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                    KIND_BYTE: begin
                        state_next = (status.byte_ok && status.last_byte) ? ST_FIN : ST_RESP;
                    end
                    KIND_READ, KIND_NOP: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_FIN: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                unique case (status.kind)
                    KIND_HEADER: cmd.do_header = 1'b1;
                    KIND_BYTE:   cmd.do_byte   = 1'b1;
                    KIND_READ:   cmd.do_read   = 1'b1;
                    KIND_NOP:    cmd.do_read   = 1'b0;
                endcase
            end
            ST_FIN: begin
                cmd.do_finish = 1'b1;
            end
            ST_RESP: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `FRAGR_ASSERT(a_fin_after_exec, aclk, aresetn, (state_reg == ST_FIN) |-> ($past(state_reg) == ST_EXEC))
    `FRAGR_ASSERT_NEXT(a_sweep_not_cut_short, aclk, aresetn, (state_reg == ST_CLEAR) && !status.clr_last, state_reg == ST_CLEAR)

endmodule

`default_nettype wire

### sv/fragment_reassembler_top.sv
// ----------------------------------------------------------------------------
// Fragment reassembler top level
// Rebuilds one message from indexed fragments and serves byte reads.
// ----------------------------------------------------------------------------
// Every transaction gets exactly one result. Items are handled one at a time
// through accept, execute and result-load steps; the payload byte that closes
// a fragment adds a finish step for the length table read-modify-write.
// A header with index zero that passes the type, length and count checks
// wipes every address of the message store (STORE_BYTES, 1024 by default)
// with a sweep before its result appears; the same sweep runs once after
// reset, and no item is taken until it ends. The store has a single write
// port, which sets the sweep length. A stalled result channel holds the
// block in its result-load cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembler_top import fragr_pkg::*; #(
    parameter int STORE_BYTES = 1024,   // message store size in bytes
    parameter int FRAG_STRIDE = 57,     // byte offset between fragment slots
    parameter int MAX_FRAGS   = 255     // largest fragment count accepted
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input transactions
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic [7:0]         s_msg_type,
    input  wire logic [7:0]         s_frag_index,
    input  wire logic [7:0]         s_frag_total,
    input  wire logic [7:0]         s_message_id,
    input  wire logic [7:0]         s_packet_len,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic [RADDR_W-1:0] s_read_addr,
    // result transactions
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_header_ok,
    output logic                    m_done_res,
    output logic [LEN_W-1:0]        m_total_length,
    output logic [7:0]              m_read_data
);

    fragr_cmd_t    cmd;
    fragr_status_t status;

    // Controller: walks each transaction through its steps and runs the
    // store wipe after reset and after a message restart.
    fragr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: header checks, write window, per-fragment length table with
    // valid bits, running length sum, message store and the result register.
    fragr_dpath #(
        .STORE_BYTES (STORE_BYTES),
        .FRAG_STRIDE (FRAG_STRIDE),
        .MAX_FRAGS   (MAX_FRAGS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_kind         (s_kind),
        .s_msg_type     (s_msg_type),
        .s_frag_index   (s_frag_index),
        .s_frag_total   (s_frag_total),
        .s_message_id   (s_message_id),
        .s_packet_len   (s_packet_len),
        .s_data_byte    (s_data_byte),
        .s_read_addr    (s_read_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_header_ok    (m_header_ok),
        .m_done_res     (m_done_res),
        .m_total_length (m_total_length),
        .m_read_data    (m_read_data)
    );

endmodule

`default_nettype wire
